>>> rtl/core/tlip_pkg.sv
`timescale 1ns / 1ps

package tlip_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CountW = 32;

  // Line limit after reset and the default storage size
  localparam logic [LenW-1:0] LineLimitReset = 13'd8000;
  localparam int unsigned     LineMaxDefault = 8192;

  // Telnet command bytes
  localparam logic [ByteW-1:0] B_IAC  = 8'hFF;
  localparam logic [ByteW-1:0] B_WILL = 8'hFB;
  localparam logic [ByteW-1:0] B_WONT = 8'hFC;
  localparam logic [ByteW-1:0] B_DO   = 8'hFD;
  localparam logic [ByteW-1:0] B_DONT = 8'hFE;

  // Telnet option codes
  localparam logic [ByteW-1:0] OPT_BINARY   = 8'h00;
  localparam logic [ByteW-1:0] OPT_ECHO     = 8'h01;
  localparam logic [ByteW-1:0] OPT_SGA      = 8'h03;
  localparam logic [ByteW-1:0] OPT_LINEMODE = 8'h22;

  // Control characters
  localparam logic [ByteW-1:0] CH_BEL = 8'h07;
  localparam logic [ByteW-1:0] CH_BS  = 8'h08;
  localparam logic [ByteW-1:0] CH_TAB = 8'h09;
  localparam logic [ByteW-1:0] CH_LF  = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR  = 8'h0D;
  localparam logic [ByteW-1:0] CH_ESC = 8'h1B;
  localparam logic [ByteW-1:0] CH_SP  = 8'h20;
  localparam logic [ByteW-1:0] CH_TLD = 8'h7E;
  localparam logic [ByteW-1:0] CH_DEL = 8'h7F;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_APPEND    = 3'd1,
    EV_ERASE_DEL = 3'd2,
    EV_ERASE_BS  = 3'd3,
    EV_LINE      = 3'd4,
    EV_REPLY     = 3'd5,
    EV_LOST      = 3'd6
  } event_code_e;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } reply_verb_e;

  // IAC sequence phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_IAC  = 3'b010,
    PH_OPT  = 3'b100
  } iac_phase_e;

  // Printable range plus the allowed control characters
  function automatic logic valid_char(input logic [ByteW-1:0] c);
    logic ok;
    ok = (c inside {[CH_SP:CH_TLD], CH_BEL, CH_TAB, CH_LF, CH_ESC, CH_DEL});
    return ok;
  endfunction

endpackage

>>> rtl/core/telnet_line_input_parser_top.sv
`timescale 1ns / 1ps

// Telnet line input parser. Takes one received byte per beat and returns one
// event per byte: append, erase echo, line done, telnet option reply, lost or
// nothing, along with the current line length and saturating lost and total
// byte counts. IAC sequences are stripped with their state kept across bytes.
// Throughput is one byte per clock cycle: the byte is
// decoded against the parser state in a single pass and the event lands in an
// output register, which takes a new byte whenever it is empty or being read
// in the same cycle. The line limit register is written through its own
// channel, which is always ready; write it only while no byte is in flight.
module telnet_line_input_parser_top #(
  parameter int unsigned LINE_MAX = tlip_pkg::LineMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tlip_pkg::ByteW-1:0]    rx_byte_i,
  // Event output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_res_o,
  output logic [tlip_pkg::ByteW-1:0]    data_byte_o,
  output logic [1:0]                    reply_verb_o,
  output logic [tlip_pkg::LenW-1:0]     line_length_o,
  output logic [tlip_pkg::CountW-1:0]   lost_count_o,
  output logic [tlip_pkg::CountW-1:0]   total_count_o,
  // Line limit register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tlip_pkg::LenW-1:0]     cfg_line_limit_i
);
  import tlip_pkg::*;

  localparam int unsigned     LenMaxAll = (1 << LenW) - 1;
  localparam logic [LenW-1:0] LineCap   =
    LenW'((LINE_MAX - 1 < LenMaxAll) ? LINE_MAX - 1 : LenMaxAll);
  localparam logic [CountW-1:0] CountSat = '1;

  logic [LenW-1:0]   limit_q;
  iac_phase_e        phase_q, phase_d;
  logic [ByteW-1:0]  pverb_q, pverb_d;
  logic              skip_lf_q, skip_lf_d;
  logic [LenW-1:0]   count_q, count_d;
  logic [CountW-1:0] lost_q, lost_d;
  logic [CountW-1:0] total_q, total_d;

  logic              out_valid_q;
  event_code_e       ev_q, ev_d;
  logic [ByteW-1:0]  data_q, data_d;
  reply_verb_e       rverb_q, rverb_d;
  logic [LenW-1:0]   len_q, len_d;

  logic              accept;
  logic [LenW-1:0]   eff_limit;
  logic [ByteW-1:0]  c;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign c           = rx_byte_i;
  assign eff_limit   = (limit_q < LineCap) ? limit_q : LineCap;

  // Hold the line limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LineLimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_line_limit_i;
    end
  end

  // Decode one byte against the parser state
  always_comb begin
    phase_d   = phase_q;
    pverb_d   = pverb_q;
    skip_lf_d = skip_lf_q;
    count_d   = count_q;
    lost_d    = lost_q;
    total_d   = total_q;
    ev_d      = EV_NONE;
    data_d    = '0;
    rverb_d   = VERB_WILL;
    len_d     = count_q;
    if (accept) begin
      if (total_q != CountSat) begin
        total_d = total_q + 1'b1;
      end
      case (phase_q)
        PH_OPT: begin
          phase_d = PH_IDLE;
          if (pverb_q == B_DO) begin
            if (c == OPT_LINEMODE) begin
              ev_d = EV_REPLY; data_d = c; rverb_d = VERB_WILL;
            end else if (c != OPT_SGA && c != OPT_BINARY) begin
              ev_d = EV_REPLY; data_d = c; rverb_d = VERB_WONT;
            end
          end else if (pverb_q == B_WILL) begin
            ev_d    = EV_REPLY;
            data_d  = c;
            rverb_d = (c == OPT_ECHO) ? VERB_DO : VERB_DONT;
          end
        end
        PH_IAC: begin
          // IAC IAC yields 0xFF, which is not a valid character: drop it
          if (c inside {[B_WILL:B_DONT]}) begin
            phase_d = PH_OPT;
            pverb_d = c;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d   = PH_IDLE;
          skip_lf_d = 1'b0;
          if (skip_lf_q && c == CH_LF) begin
            // drop LF of a CR LF pair
          end else if (c == B_IAC) begin
            phase_d = PH_IAC;
          end else if (c == CH_LF || c == CH_CR) begin
            skip_lf_d = (c == CH_CR);
            if (count_q != '0) begin
              ev_d    = EV_LINE;
              count_d = '0;
            end
          end else if (c == CH_BS || c == CH_DEL) begin
            ev_d = (c == CH_DEL) ? EV_ERASE_DEL : EV_ERASE_BS;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
            len_d = count_d;
          end else if (!valid_char(c)) begin
            // drop disallowed control byte
          end else if (count_q < eff_limit) begin
            count_d = count_q + 1'b1;
            ev_d    = EV_APPEND;
            data_d  = c;
            len_d   = count_d;
          end else begin
            if (lost_q != CountSat) begin
              lost_d = lost_q + 1'b1;
            end
            ev_d = EV_LOST;
          end
        end
      endcase
    end
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pverb_q   <= '0;
      skip_lf_q <= 1'b0;
      count_q   <= '0;
      lost_q    <= '0;
      total_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pverb_q   <= pverb_d;
      skip_lf_q <= skip_lf_d;
      count_q   <= count_d;
      lost_q    <= lost_d;
      total_q   <= total_d;
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the event payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q    <= ev_d;
      data_q  <= data_d;
      rverb_q <= rverb_d;
      len_q   <= len_d;
    end
  end

  // Counters change only on accept, so they match the beat on display
  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign data_byte_o   = data_q;
  assign reply_verb_o  = rverb_q;
  assign line_length_o = len_q;
  assign lost_count_o  = lost_q;
  assign total_count_o = total_q;

  // An accepted byte always yields an output beat
  a_accept_gives_beat: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o
  ) else $error("accepted byte produced no output beat");

  // The line never grows beyond the storage cap
  a_count_capped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= LineCap
  ) else $error("line count beyond cap");

  // An appended character leaves a non-empty line
  a_append_nonempty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_APPEND) |-> (line_length_o != '0)
  ) else $error("append with zero line length");

  // Total count steps by one on each accepted byte until saturation
  a_total_steps: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && total_q != CountSat) |=> (total_q == $past(total_q) + 1'b1)
  ) else $error("total count did not advance");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tlip_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseBytes = 178;

  // One parser event as it leaves the block
  typedef struct {
    event_code_e       ev;
    logic [ByteW-1:0]  data;
    reply_verb_e       verb;
    logic [LenW-1:0]   len;
    logic [CountW-1:0] lost;
    logic [CountW-1:0] total;
  } line_event_t;

  // Tracks the parser state and queues the event each byte should cause
  class line_event_board;
    line_event_t       pending_events[$];
    int                error_count = 0;
    logic [LenW-1:0]   limit       = LineLimitReset;
    iac_phase_e        phase       = PH_IDLE;
    logic [ByteW-1:0]  verb_byte   = '0;
    bit                skip_lf     = 1'b0;
    logic [LenW-1:0]   line_len    = '0;
    logic [CountW-1:0] lost_total  = '0;
    logic [CountW-1:0] byte_total  = '0;

    function void set_limit(logic [LenW-1:0] v);
      limit = v;
    endfunction

    function bit keeps_char(logic [ByteW-1:0] c);
      return (c >= CH_SP && c <= CH_TLD) || c == CH_BEL || c == CH_TAB ||
             c == CH_LF || c == CH_ESC || c == CH_DEL;
    endfunction

    // Advance the parser by one byte and queue the event it causes
    function void note_byte(logic [ByteW-1:0] c);
      line_event_t e;
      int          room;
      e.ev   = EV_NONE;
      e.data = '0;
      e.verb = VERB_WILL;
      room   = (int'(limit) < LineMaxDefault - 1) ? int'(limit) : LineMaxDefault - 1;
      if (byte_total != '1) byte_total++;
      case (phase)
        PH_OPT: begin
          phase = PH_IDLE;
          if (verb_byte == B_DO) begin
            if (c == OPT_LINEMODE) begin
              e.ev = EV_REPLY; e.data = c; e.verb = VERB_WILL;
            end else if (c != OPT_SGA && c != OPT_BINARY) begin
              e.ev = EV_REPLY; e.data = c; e.verb = VERB_WONT;
            end
          end else if (verb_byte == B_WILL) begin
            e.ev   = EV_REPLY;
            e.data = c;
            e.verb = (c == OPT_ECHO) ? VERB_DO : VERB_DONT;
          end
        end
        PH_IAC: begin
          if (c >= B_WILL && c <= B_DONT) begin
            phase     = PH_OPT;
            verb_byte = c;
          end else begin
            phase = PH_IDLE;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (skip_lf && c == CH_LF) begin
            skip_lf = 1'b0;
          end else begin
            skip_lf = 1'b0;
            if (c == B_IAC) begin
              phase = PH_IAC;
            end else if (c == CH_LF || c == CH_CR) begin
              skip_lf = (c == CH_CR);
              if (line_len != 0) e.ev = EV_LINE;
            end else if (c == CH_BS || c == CH_DEL) begin
              e.ev = (c == CH_DEL) ? EV_ERASE_DEL : EV_ERASE_BS;
              if (line_len != 0) line_len--;
            end else if (!keeps_char(c)) begin
              e.ev = EV_NONE;
            end else if (line_len < room) begin
              line_len++;
              e.ev   = EV_APPEND;
              e.data = c;
            end else begin
              if (lost_total != '1) lost_total++;
              e.ev = EV_LOST;
            end
          end
        end
      endcase
      // A finished line reports its own length, then the line restarts
      e.len   = line_len;
      e.lost  = lost_total;
      e.total = byte_total;
      if (e.ev == EV_LINE) line_len = '0;
      pending_events.push_back(e);
    endfunction

    function void compare_field(string name, logic [CountW-1:0] exp_v,
                                logic [CountW-1:0] act_v);
      if (exp_v !== act_v) begin
        error_count++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one output beat with the oldest queued event
    function void check_event(logic [2:0] ev, logic [ByteW-1:0] data, logic [1:0] verb,
                              logic [LenW-1:0] len, logic [CountW-1:0] lost,
                              logic [CountW-1:0] total);
      line_event_t e;
      if (pending_events.size() == 0) begin
        error_count++;
        $display("%0t: event beat with none queued, expected nothing, got event %0d",
                 $time, ev);
        return;
      end
      e = pending_events.pop_front();
      compare_field("event_res", CountW'(e.ev), CountW'(ev));
      compare_field("data_byte", CountW'(e.data), CountW'(data));
      compare_field("reply_verb", CountW'(e.verb), CountW'(verb));
      compare_field("line_length", CountW'(e.len), CountW'(len));
      compare_field("lost_count", e.lost, lost);
      compare_field("total_count", e.total, total);
    endfunction
  endclass

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [ByteW-1:0]    rx_byte_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [2:0]          event_res_o;
  logic [ByteW-1:0]    data_byte_o;
  logic [1:0]          reply_verb_o;
  logic [LenW-1:0]     line_length_o;
  logic [CountW-1:0]   lost_count_o;
  logic [CountW-1:0]   total_count_o;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [LenW-1:0]     cfg_line_limit_i = '0;

  line_event_board board = new;
  int unsigned     snd_idle_pct = 25;
  int unsigned     rcv_idle_pct = 79;
  int unsigned     bytes_sent   = 0;
  int unsigned     cycle_count  = 0;

  telnet_line_input_parser_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .data_byte_o      (data_byte_o),
    .reply_verb_o     (reply_verb_o),
    .line_length_o    (line_length_o),
    .lost_count_o     (lost_count_o),
    .total_count_o    (total_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_line_limit_i (cfg_line_limit_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the event output at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watch all three channels: feed the tracker first, then check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.set_limit(cfg_line_limit_i);
      if (in_valid_i && in_ready_o) board.note_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        board.check_event(event_res_o, data_byte_o, reply_verb_o, line_length_o,
                          lost_count_o, total_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Idle a random number of cycles, then hold the byte until it is taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic write_limit(input logic [LenW-1:0] v);
    cfg_valid_i      <= 1'b1;
    cfg_line_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued event has come out
  task automatic settle();
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Mostly well-formed text, edits, line ends and telnet commands, plus noise
  task automatic send_mix(input int unsigned n);
    logic [ByteW-1:0] opt_codes[4] = '{OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_LINEMODE};
    int unsigned      stop_at;
    int unsigned      kind;
    logic [ByteW-1:0] verb;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        send_byte(ByteW'($urandom_range(CH_TLD, CH_SP)));
      end else if (kind < 55) begin
        send_byte($urandom_range(1) ? CH_BS : CH_DEL);
      end else if (kind < 65) begin
        case ($urandom_range(2))
          0: send_byte(CH_CR);
          1: send_byte(CH_LF);
          default: begin
            send_byte(CH_CR);
            send_byte(CH_LF);
          end
        endcase
      end else if (kind < 80) begin
        send_byte(B_IAC);
        if ($urandom_range(3) == 0) verb = ByteW'($urandom_range(B_IAC, 8'hF0));
        else verb = ByteW'($urandom_range(B_DONT, B_WILL));
        send_byte(verb);
        if (verb >= B_WILL && verb <= B_DONT) begin
          if ($urandom_range(1)) send_byte(opt_codes[2'($urandom_range(3))]);
          else send_byte(ByteW'($urandom_range(255)));
        end
      end else if (kind < 90) begin
        send_byte(ByteW'($urandom_range(CH_SP - 1)));
      end else begin
        send_byte(ByteW'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [ByteW-1:0] opening[25] = '{
      8'h41, 8'h42, CH_BS, CH_DEL, CH_DEL, CH_CR, CH_LF, 8'h78, CH_CR, 8'h00,
      CH_LF, B_IAC, B_IAC, B_IAC, B_DO, OPT_LINEMODE, B_IAC, B_DO, OPT_SGA,
      B_IAC, B_WILL, OPT_ECHO, B_IAC, 8'hF1, CH_TLD
    };
    logic [LenW-1:0] phase_limit[NumPhases] = '{
      LineLimitReset, 13'd0, 13'd1, 13'h1FFF, 13'd5, 13'd0, 13'd3, 13'h1000, 13'd0
    };
    int unsigned ph;

    // Hold reset, then release
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short directed run under the reset line limit
    foreach (opening[i]) send_byte(opening[i]);

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph / 3)
        0: begin
          snd_idle_pct = 25;
          rcv_idle_pct = 79;
        end
        1: begin
          snd_idle_pct = 79;
          rcv_idle_pct = 25;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (ph != 0) begin
        in_valid_i <= 1'b0;
        settle();
        if (ph == 5) phase_limit[ph] = LenW'($urandom_range(30, 2));
        if (ph == 8) phase_limit[ph] = LenW'($urandom_range(8191, 1));
        write_limit(phase_limit[ph]);
      end
      send_mix(PhaseBytes);
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    settle();
    repeat (10) @(posedge clk_i);
    if (board.error_count == 0 && board.pending_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
